// ----- rtl/core/kmc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kmc_pkg: shared types and constants for the k-means clustering block
// Sizes, register indexes, controller states and the structs that pass
// between the controller and the row of cluster cells.
// ----------------------------------------------------------------------------
package kmc_pkg;

   localparam int MAX_CLUSTERS  = 8;
   localparam int MAX_DIMENSION = 8;
   localparam int MAX_POINTS    = 1024;

   localparam int CL_W       = $clog2(MAX_CLUSTERS);
   localparam int DM_W       = $clog2(MAX_DIMENSION);
   localparam int K_W        = 4;
   localparam int POINT_CAP  = MAX_POINTS * MAX_DIMENSION;
   localparam int PA_W       = $clog2(POINT_CAP);
   localparam int CENT_CAP   = MAX_CLUSTERS * MAX_DIMENSION;
   localparam int CA_W       = $clog2(CENT_CAP);
   localparam int COORD_W    = 16;
   localparam int SUM_W      = 28;
   localparam int CNT_W      = 11;
   localparam int SQ_W       = 2 * (COORD_W + 1);
   localparam int DIST_W     = SQ_W + DM_W;
   localparam int ITER_W     = 16;
   localparam int THR_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int DIV_CNT_W  = $clog2(SUM_W);

   localparam logic [CSR_IDX_W-1:0] REG_NUM_CLUSTERS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DIMENSION    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_ITER     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD    = 3'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIST,
      ST_DIST_END,
      ST_ITER,
      ST_FEED_A,
      ST_WAIT_A,
      ST_FEED_B,
      ST_DRAIN,
      ST_UPD_SEL,
      ST_UPD_DIV,
      ST_UPD_WAIT,
      ST_UPD_SQ,
      ST_UPD_ACC,
      ST_UPD_END,
      ST_CHECK,
      ST_EMIT
   } state_type;

   // one coordinate travelling down the cell row
   typedef struct packed {
      logic                      valid;
      logic                      phase_b;  // 0: distance pass, 1: accumulate pass
      logic                      first;
      logic                      last;
      logic [DM_W-1:0]           j;
      logic [CL_W-1:0]           tag;      // winning cluster in accumulate pass
      logic signed [COORD_W-1:0] value;
   } stream_type;

   // running nearest centroid
   typedef struct packed {
      logic              valid;
      logic [DIST_W-1:0] dist_val;
      logic [CL_W-1:0]   idx;
   } best_type;

   // controller to cells
   typedef struct packed {
      logic                      clear;
      logic                      load_en;
      logic [CL_W-1:0]           load_c;
      logic [DM_W-1:0]           load_j;
      logic signed [COORD_W-1:0] load_val;
      logic [DM_W-1:0]           rd_j;
      logic [K_W-1:0]            k;
   } ctrl_type;

endpackage
`default_nettype wire

// ----- rtl/core/kmeans_clustering.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kmeans_clustering: Lloyd k-means on signed Q8.8 coordinates
// Loads points and initial centroids, iterates assign/update in a row of
// cluster cells, then returns the final centroids one coordinate at a time.
// ----------------------------------------------------------------------------
//
//  channel  ports                               direction  handshake
//  req      req_target/coord_value/last         in         valid/stall
//  rsp      rsp_cluster_index/coord_index/...   out        valid/stall
//  csr      csr_index/csr_data                  in         valid/ready
//
//  Load transactions are taken one per cycle while idle. The transaction with
//  req_last starts the run; req_stall stays high until the last result is
//  loaded into the output register. Per point: a distance pass, a wait
//  until the winner leaves the last of the 8 cells, then an accumulate pass.
//  Update: each coordinate of each non-empty cluster goes through the
//  serial divider. Results go out one per cycle unless rsp_stall is high.
//  Synchronous reset sets control and config state only; no clearing pass.
//
module kmeans_clustering (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_target,
   input  logic signed [kmc_pkg::COORD_W-1:0]    req_coord_value,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [kmc_pkg::CL_W-1:0]              rsp_cluster_index,
   output logic [kmc_pkg::DM_W-1:0]              rsp_coord_index,
   output logic signed [kmc_pkg::COORD_W-1:0]    rsp_centroid_value,
   output logic                                  rsp_converged,
   output logic                                  rsp_end_of_run,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [kmc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [kmc_pkg::CSR_DATA_W-1:0]        csr_data
);
   import kmc_pkg::*;

   // configuration
   logic [K_W-1:0]    num_clusters_ff;
   logic [K_W-1:0]    dimension_ff;
   logic [ITER_W-1:0] max_iter_ff;
   logic [THR_W-1:0]  thr_ff;
   logic [K_W-1:0]    k_eff;
   logic [K_W-1:0]    d_eff;

   // memories
   logic signed [COORD_W-1:0] pmem [POINT_CAP];
   logic signed [COORD_W-1:0] cmem [CENT_CAP];
   logic signed [COORD_W-1:0] pmem_q;
   logic signed [COORD_W-1:0] cmem_q;

   // control
   state_type         state_ff, state_in;
   logic [PA_W:0]     pwp_ff;
   logic [CA_W:0]     cwp_ff;
   logic [K_W-1:0]    c_ff;
   logic [K_W-1:0]    j_ff;
   logic [CA_W-1:0]   a_ff;
   logic [PA_W:0]     base_ff;
   logic [ITER_W-1:0] it_ff;
   logic              conv_ff;
   logic              still_ff;
   logic [CL_W-1:0]   win_ff;
   logic [1:0]        pend_ff;
   logic              ld_v_ff;
   logic [CL_W-1:0]   ld_c_ff;
   logic [DM_W-1:0]   ld_j_ff;
   logic signed [COORD_W-1:0] mean_ff;
   logic [SQ_W-1:0]   usq_ff;
   logic [DIST_W-1:0] move_ff;

   // feed stage in front of cell 0
   logic              fd_v_ff;
   logic              fd_b_ff;
   logic              fd_first_ff;
   logic              fd_last_ff;
   logic [DM_W-1:0]   fd_j_ff;
   logic [CL_W-1:0]   fd_tag_ff;

   // output register
   logic              rsp_v_ff;
   logic [CL_W-1:0]   rsp_c_ff;
   logic [DM_W-1:0]   rsp_j_ff;
   logic signed [COORD_W-1:0] rsp_val_ff;
   logic              rsp_conv_ff;
   logic              rsp_end_ff;

   // decoded control
   logic              req_fire;
   logic              j_last;
   logic              c_last;
   logic              pts_first;
   logic              pts_next;
   logic              emit_fire;
   logic              div_start;
   logic              div_done;
   logic signed [SUM_W-1:0] div_q;
   logic [PA_W-1:0]   p_raddr;
   ctrl_type          ctrl;

   // cell row
   stream_type        s_w [MAX_CLUSTERS];
   best_type          b_w [MAX_CLUSTERS];
   stream_type        s_tail;
   best_type          b_tail;
   logic signed [COORD_W-1:0] cent_w [MAX_CLUSTERS];
   logic signed [SUM_W-1:0]   sum_w  [MAX_CLUSTERS];
   logic [CNT_W-1:0]          cnt_w  [MAX_CLUSTERS];
   logic signed [COORD_W-1:0] cent_cur;
   logic signed [SUM_W-1:0]   sum_cur;
   logic [CNT_W-1:0]          cnt_cur;
   logic signed [COORD_W:0]   udiff;
   logic signed [SQ_W-1:0]    usq;
   logic                      tail_b_last;

   //---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_clusters_ff <= K_W'(2);
         dimension_ff    <= K_W'(2);
         max_iter_ff     <= ITER_W'(200);
         thr_ff          <= THR_W'(7);
      end else if (csr_valid) begin
         case (csr_index)
            REG_NUM_CLUSTERS: num_clusters_ff <= csr_data[K_W-1:0];
            REG_DIMENSION:    dimension_ff    <= csr_data[K_W-1:0];
            REG_MAX_ITER:     max_iter_ff     <= csr_data[ITER_W-1:0];
            REG_THRESHOLD:    thr_ff          <= csr_data[THR_W-1:0];
            default: ;
         endcase
      end
   end

   // out-of-range K and d are clamped
   always_comb begin
      if (num_clusters_ff == '0) begin
         k_eff = K_W'(1);
      end else if (num_clusters_ff > K_W'(MAX_CLUSTERS)) begin
         k_eff = K_W'(MAX_CLUSTERS);
      end else begin
         k_eff = num_clusters_ff;
      end
      if (dimension_ff == '0) begin
         d_eff = K_W'(1);
      end else if (dimension_ff > K_W'(MAX_DIMENSION)) begin
         d_eff = K_W'(MAX_DIMENSION);
      end else begin
         d_eff = dimension_ff;
      end
   end

   //---------------------------------------------------------------- decode
   always_comb begin
      req_fire    = req_valid && !req_stall;
      j_last      = (j_ff == d_eff - 1'b1);
      c_last      = (c_ff == k_eff - 1'b1);
      pts_first   = ({{(PA_W+1-K_W){1'b0}}, d_eff} <= pwp_ff);
      pts_next    = ((PA_W+2)'(base_ff) + (PA_W+2)'({d_eff, 1'b0})) <= (PA_W+2)'(pwp_ff);
      emit_fire   = (state_ff == ST_EMIT) && (!rsp_v_ff || !rsp_stall);
      tail_b_last = s_tail.valid && s_tail.phase_b && s_tail.last;
      cent_cur    = cent_w[c_ff[CL_W-1:0]];
      sum_cur     = sum_w[c_ff[CL_W-1:0]];
      cnt_cur     = cnt_w[c_ff[CL_W-1:0]];
      udiff       = {mean_ff[COORD_W-1], mean_ff} - {cent_cur[COORD_W-1], cent_cur};
      usq         = udiff * udiff;
      p_raddr     = PA_W'(base_ff + (PA_W+1)'(j_ff));
   end

   //---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_fire && req_last) state_in = ST_DIST;
         ST_DIST:     if (c_last && j_last) state_in = ST_DIST_END;
         ST_DIST_END: state_in = (max_iter_ff == '0) ? ST_EMIT : ST_ITER;
         ST_ITER:     state_in = pts_first ? ST_FEED_A : ST_DRAIN;
         ST_FEED_A:   if (j_last) state_in = ST_WAIT_A;
         ST_WAIT_A:   if (b_tail.valid) state_in = ST_FEED_B;
         ST_FEED_B:   if (j_last) state_in = pts_next ? ST_FEED_A : ST_DRAIN;
         ST_DRAIN:    if (pend_ff == '0) state_in = ST_UPD_SEL;
         ST_UPD_SEL: begin
            if (c_ff == k_eff) begin
               state_in = ST_CHECK;
            end else if (cnt_cur != '0) begin
               state_in = ST_UPD_DIV;
            end
         end
         ST_UPD_DIV:  state_in = ST_UPD_WAIT;
         ST_UPD_WAIT: if (div_done) state_in = ST_UPD_SQ;
         ST_UPD_SQ:   state_in = ST_UPD_ACC;
         ST_UPD_ACC:  state_in = j_last ? ST_UPD_END : ST_UPD_DIV;
         ST_UPD_END:  state_in = ST_UPD_SEL;
         ST_CHECK: begin
            if (still_ff || ((ITER_W+1)'(it_ff) + 1'b1 >= (ITER_W+1)'(max_iter_ff))) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_ITER;
            end
         end
         ST_EMIT:     if (emit_fire && c_last && j_last) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   //---------------------------------------------------------------- outputs
   always_comb begin
      req_stall     = (state_ff != ST_IDLE);
      div_start     = (state_ff == ST_UPD_DIV);
      ctrl          = '0;
      ctrl.k        = k_eff;
      ctrl.rd_j     = j_ff[DM_W-1:0];
      ctrl.clear    = (state_ff == ST_ITER);
      case (state_ff)
         ST_UPD_SQ: begin
            ctrl.load_en  = 1'b1;
            ctrl.load_c   = c_ff[CL_W-1:0];
            ctrl.load_j   = j_ff[DM_W-1:0];
            ctrl.load_val = mean_ff;
         end
         default: begin
            ctrl.load_en  = ld_v_ff;
            ctrl.load_c   = ld_c_ff;
            ctrl.load_j   = ld_j_ff;
            ctrl.load_val = cmem_q;
         end
      endcase
   end

   //---------------------------------------------------------------- memories
   always_ff @(posedge clock) begin
      if (req_fire && !req_target && (pwp_ff < (PA_W+1)'(POINT_CAP))) begin
         pmem[pwp_ff[PA_W-1:0]] <= req_coord_value;
      end
      pmem_q <= pmem[p_raddr];
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_target && (cwp_ff < (CA_W+1)'(CENT_CAP))) begin
         cmem[cwp_ff[CA_W-1:0]] <= req_coord_value;
      end else if (emit_fire) begin
         cmem[a_ff] <= cent_cur;
      end
      cmem_q <= cmem[a_ff];
   end

   //---------------------------------------------------------------- control regs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pwp_ff   <= '0;
         cwp_ff   <= '0;
         ld_v_ff  <= 1'b0;
         fd_v_ff  <= 1'b0;
         pend_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ld_v_ff  <= (state_ff == ST_DIST);
         fd_v_ff  <= (state_ff == ST_FEED_A) || (state_ff == ST_FEED_B);
         if (req_fire) begin
            if (req_target) begin
               if (cwp_ff < (CA_W+1)'(CENT_CAP)) cwp_ff <= cwp_ff + 1'b1;
            end else begin
               if (pwp_ff < (PA_W+1)'(POINT_CAP)) pwp_ff <= pwp_ff + 1'b1;
            end
         end
         if (emit_fire && c_last && j_last) begin
            pwp_ff <= '0;
            cwp_ff <= '0;
         end
         case ({(state_ff == ST_FEED_B) && j_last, tail_b_last})
            2'b10:   pend_ff <= pend_ff + 1'b1;
            2'b01:   pend_ff <= pend_ff - 1'b1;
            default: pend_ff <= pend_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      ld_c_ff     <= c_ff[CL_W-1:0];
      ld_j_ff     <= j_ff[DM_W-1:0];
      fd_b_ff     <= (state_ff == ST_FEED_B);
      fd_first_ff <= (j_ff == '0);
      fd_last_ff  <= j_last;
      fd_j_ff     <= j_ff[DM_W-1:0];
      fd_tag_ff   <= win_ff;
      case (state_ff)
         ST_IDLE: begin
            c_ff <= '0;
            j_ff <= '0;
            a_ff <= '0;
         end
         ST_DIST: begin
            a_ff <= a_ff + 1'b1;
            if (j_last) begin
               j_ff <= '0;
               c_ff <= c_ff + 1'b1;
            end else begin
               j_ff <= j_ff + 1'b1;
            end
         end
         ST_DIST_END: begin
            it_ff   <= '0;
            conv_ff <= 1'b0;
            c_ff    <= '0;
            j_ff    <= '0;
            a_ff    <= '0;
         end
         ST_ITER: begin
            base_ff  <= '0;
            j_ff     <= '0;
            c_ff     <= '0;
            still_ff <= 1'b1;
         end
         ST_FEED_A: j_ff <= j_last ? '0 : j_ff + 1'b1;
         ST_WAIT_A: win_ff <= b_tail.idx;
         ST_FEED_B: begin
            if (j_last) begin
               j_ff    <= '0;
               base_ff <= base_ff + (PA_W+1)'(d_eff);
            end else begin
               j_ff <= j_ff + 1'b1;
            end
         end
         ST_UPD_SEL: begin
            j_ff    <= '0;
            move_ff <= '0;
            if ((c_ff != k_eff) && (cnt_cur == '0)) c_ff <= c_ff + 1'b1;
         end
         ST_UPD_WAIT: if (div_done) mean_ff <= div_q[COORD_W-1:0];
         ST_UPD_SQ:   usq_ff <= SQ_W'(usq);
         ST_UPD_ACC: begin
            move_ff <= move_ff + DIST_W'(usq_ff);
            if (!j_last) j_ff <= j_ff + 1'b1;
         end
         ST_UPD_END: begin
            if (move_ff > DIST_W'(thr_ff)) still_ff <= 1'b0;
            c_ff <= c_ff + 1'b1;
         end
         ST_CHECK: begin
            it_ff   <= it_ff + 1'b1;
            conv_ff <= still_ff;
            c_ff    <= '0;
            j_ff    <= '0;
            a_ff    <= '0;
         end
         ST_EMIT: begin
            if (emit_fire) begin
               a_ff <= a_ff + 1'b1;
               if (j_last) begin
                  j_ff <= '0;
                  c_ff <= c_ff + 1'b1;
               end else begin
                  j_ff <= j_ff + 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   //---------------------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (emit_fire) begin
         rsp_v_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_c_ff    <= c_ff[CL_W-1:0];
         rsp_j_ff    <= j_ff[DM_W-1:0];
         rsp_val_ff  <= cent_cur;
         rsp_conv_ff <= conv_ff;
         rsp_end_ff  <= c_last && j_last;
      end
   end

   assign rsp_valid          = rsp_v_ff;
   assign rsp_cluster_index  = rsp_c_ff;
   assign rsp_coord_index    = rsp_j_ff;
   assign rsp_centroid_value = rsp_val_ff;
   assign rsp_converged      = rsp_conv_ff;
   assign rsp_end_of_run     = rsp_end_ff;

   //---------------------------------------------------------------- cell row
   always_comb begin
      s_w[0].valid   = fd_v_ff;
      s_w[0].phase_b = fd_b_ff;
      s_w[0].first   = fd_first_ff;
      s_w[0].last    = fd_last_ff;
      s_w[0].j       = fd_j_ff;
      s_w[0].tag     = fd_tag_ff;
      s_w[0].value   = pmem_q;
      b_w[0]         = '0;
   end

   for (genvar i = 0; i < MAX_CLUSTERS; i++) begin : g_cell
      stream_type so;
      best_type   bo;
      kmc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (CL_W'(i)),
         .ctrl     (ctrl),
         .s_in     (s_w[i]),
         .best_in  (b_w[i]),
         .s_out    (so),
         .best_out (bo),
         .cent_rd  (cent_w[i]),
         .sum_rd   (sum_w[i]),
         .cnt_rd   (cnt_w[i])
      );
      if (i == MAX_CLUSTERS - 1) begin : g_tail
         assign s_tail = so;
         assign b_tail = bo;
      end else begin : g_link
         assign s_w[i+1] = so;
         assign b_w[i+1] = bo;
      end
   end

   kmc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_cur),
      .divisor  (cnt_cur),
      .done     (div_done),
      .quotient (div_q)
   );

   //---------------------------------------------------------------- checks
   a_last_goes_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last |=> req_stall)
      else $error("run did not start after last load transaction");

   a_winner_in_wait: assert property (@(posedge clock) disable iff (reset)
      b_tail.valid |-> state_ff == ST_WAIT_A)
      else $error("nearest centroid arrived outside wait state");

   a_end_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_end_of_run |=> !rsp_valid)
      else $error("result after end of run");

endmodule
`default_nettype wire

// ----- rtl/core/kmc_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kmc_div: serial signed divider
// Signed sum over unsigned count, truncated toward zero, one bit per cycle.
// ----------------------------------------------------------------------------
module kmc_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [kmc_pkg::SUM_W-1:0]  dividend,
   input  logic [kmc_pkg::CNT_W-1:0]         divisor,
   output logic                              done,
   output logic signed [kmc_pkg::SUM_W-1:0]  quotient
);
   import kmc_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [CNT_W:0]       rem_ff;
   logic [SUM_W-1:0]     quo_ff;
   logic [CNT_W-1:0]     dvs_ff;
   logic                 neg_ff;

   logic [CNT_W:0]       shifted;
   logic                 ge;
   logic [CNT_W:0]       rem_in;

   always_comb begin
      shifted = {rem_ff[CNT_W-1:0], quo_ff[SUM_W-1]};
      ge      = shifted >= {1'b0, dvs_ff};
      rem_in  = ge ? shifted - {1'b0, dvs_ff} : shifted;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == '0)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[SUM_W-1];
         quo_ff <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
         rem_ff <= '0;
         dvs_ff <= divisor;
         cnt_ff <= DIV_CNT_W'(SUM_W - 1);
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[SUM_W-2:0], ge};
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule
`default_nettype wire

// ----- rtl/core/kmc_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kmc_cell: one cluster of the cell row
// Holds one centroid, its coordinate sums and point count. Forwards the
// coordinate stream and the running nearest centroid to its neighbor.
// ----------------------------------------------------------------------------
module kmc_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [kmc_pkg::CL_W-1:0]           cell_idx,
   input  kmc_pkg::ctrl_type                  ctrl,
   input  kmc_pkg::stream_type                s_in,
   input  kmc_pkg::best_type                  best_in,
   output kmc_pkg::stream_type                s_out,
   output kmc_pkg::best_type                  best_out,
   output logic signed [kmc_pkg::COORD_W-1:0] cent_rd,
   output logic signed [kmc_pkg::SUM_W-1:0]   sum_rd,
   output logic [kmc_pkg::CNT_W-1:0]          cnt_rd
);
   import kmc_pkg::*;

   logic signed [COORD_W-1:0] cent_ff [MAX_DIMENSION];
   logic signed [SUM_W-1:0]   sum_ff  [MAX_DIMENSION];
   logic [CNT_W-1:0]          cnt_ff;

   logic                      s_v_ff;
   stream_type                s_pl_ff;
   logic                      sq_v_ff;
   logic                      sq_first_ff;
   logic                      sq_last_ff;
   logic [SQ_W-1:0]           sq_ff;
   logic [DIST_W-1:0]         acc_ff;
   logic                      best_v_ff;
   best_type                  best_pl_ff;

   logic [DM_W-1:0]           addr;
   logic signed [COORD_W-1:0] cent_sel;
   logic signed [SUM_W-1:0]   sum_sel;
   logic                      active;
   logic signed [COORD_W:0]   diff;
   logic signed [SQ_W-1:0]    sq_in;
   logic [DIST_W-1:0]         acc_in;
   logic                      hit;

   always_comb begin
      // stream has the port while it flows, the controller otherwise
      addr     = s_in.valid ? s_in.j : ctrl.rd_j;
      cent_sel = cent_ff[addr];
      sum_sel  = sum_ff[addr];
      active   = {1'b0, cell_idx} < ctrl.k;
      diff     = {cent_sel[COORD_W-1], cent_sel} - {s_in.value[COORD_W-1], s_in.value};
      sq_in    = diff * diff;
      acc_in   = (sq_first_ff ? '0 : acc_ff) + DIST_W'(sq_ff);
      hit      = s_in.valid && s_in.phase_b && (s_in.tag == cell_idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_v_ff    <= 1'b0;
         sq_v_ff   <= 1'b0;
         best_v_ff <= 1'b0;
      end else begin
         s_v_ff    <= s_in.valid;
         sq_v_ff   <= s_in.valid && !s_in.phase_b;
         best_v_ff <= sq_v_ff && sq_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      s_pl_ff     <= s_in;
      sq_ff       <= SQ_W'(sq_in);
      sq_first_ff <= s_in.first;
      sq_last_ff  <= s_in.last;
      if (sq_v_ff) begin
         acc_ff <= acc_in;
      end
      if (sq_v_ff && sq_last_ff) begin
         if (active && ((cell_idx == '0) || (acc_in < best_in.dist_val))) begin
            best_pl_ff.dist_val <= acc_in;
            best_pl_ff.idx      <= cell_idx;
         end else begin
            best_pl_ff.dist_val <= best_in.dist_val;
            best_pl_ff.idx      <= best_in.idx;
         end
      end
      best_pl_ff.valid <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         cnt_ff <= '0;
         for (int i = 0; i < MAX_DIMENSION; i++) begin
            sum_ff[i] <= '0;
         end
      end else if (hit) begin
         sum_ff[addr] <= sum_sel + SUM_W'(s_in.value);
         if (s_in.last) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
      if (ctrl.load_en && (ctrl.load_c == cell_idx)) begin
         cent_ff[ctrl.load_j] <= ctrl.load_val;
      end
   end

   always_comb begin
      s_out          = s_pl_ff;
      s_out.valid    = s_v_ff;
      best_out       = best_pl_ff;
      best_out.valid = best_v_ff;
   end

   assign cent_rd = cent_sel;
   assign sum_rd  = sum_sel;
   assign cnt_rd  = cnt_ff;

endmodule
`default_nettype wire
